// ===== src/sopm_pkg.sv =====
// Package for the second-order plant model: field widths, fixed-point
// formats, plant mode codes and the Q2.14 coefficient tables.
// No dependencies.
package sopm_pkg;

  // Field and format widths
  localparam int SAMPLE_W        = 8;
  localparam int MODE_W          = 3;
  localparam int OUT_W           = 8;
  localparam int FRAC_BITS       = 8;
  localparam int COEF_FRAC       = 14;
  localparam int COEF_W          = 16;
  localparam int STATE_WIDTH_DEF = 24;

  // Plant modes that select a coefficient set; all others pass through
  localparam logic [MODE_W-1:0] MODE_PLANT_FIRST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PLANT_LAST  = 3'd4;

  // Largest output code
  localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t b;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // Coefficient set for a plant mode, indexed by mode minus one
  function automatic coef_set_t coef_lookup(input logic [1:0] idx);
    coef_set_t c;
    case (idx)
      2'd0:    c = '{b: 16'sd958,  a1: 16'sd22086, a2: 16'sd6662};
      2'd1:    c = '{b: 16'sd1316, a1: 16'sd28475, a2: 16'sd13414};
      2'd2:    c = '{b: 16'sd1453, a1: 16'sd31310, a2: 16'sd16384};
      2'd3:    c = '{b: 16'sd1092, a1: 16'sd24281, a2: 16'sd8992};
      default: c = '{b: 16'sd0,    a1: 16'sd0,     a2: 16'sd0};
    endcase
    return c;
  endfunction

endpackage

// ===== src/sopm_recur.sv =====
// Recurrence of the second-order plant: history registers, the three
// coefficient products, floor shift and saturation of the new state.
// Depends on sopm_pkg.
module sopm_recur import sopm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [SAMPLE_W-1:0]           sample,
  input  logic                          drive_high,
  input  logic [MODE_W-1:0]             plant_mode,
  output logic signed [STATE_WIDTH-1:0] y
);

  localparam int XQ_W = SAMPLE_W + FRAC_BITS;
  localparam int PB_W = COEF_W + XQ_W + 1;
  localparam int PA_W = COEF_W + STATE_WIDTH;
  localparam int AW   = STATE_WIDTH + 18;

  localparam logic signed [AW-1:0] ST_MAX =
    $signed({{(AW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}});
  localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;

  logic [SAMPLE_W-1:0]           last_sample_r;
  logic signed [STATE_WIDTH-1:0] hist_one_r, hist_two_r;

  coef_set_t                     cs;
  logic                          use_plant;
  logic [1:0]                    mode_idx;
  logic signed [PB_W-1:0]        prod_b;
  logic signed [PA_W-1:0]        prod_a1, prod_a2;
  logic signed [AW-1:0]          acc, acc_sh, pass_v, sel;

  // Pick the coefficient set
  assign use_plant = drive_high &&
                     (plant_mode inside {[MODE_PLANT_FIRST:MODE_PLANT_LAST]});
  assign mode_idx  = 2'(plant_mode - MODE_PLANT_FIRST);
  assign cs        = coef_lookup(mode_idx);

  // Form the three products and sum them with 22 fraction bits
  assign prod_b  = PB_W'(cs.b) * $signed({1'b0, last_sample_r, {FRAC_BITS{1'b0}}});
  assign prod_a1 = PA_W'(cs.a1) * PA_W'(hist_one_r);
  assign prod_a2 = PA_W'(cs.a2) * PA_W'(hist_two_r);
  assign acc     = AW'(prod_b) + AW'(prod_a1) - AW'(prod_a2);

  // Drop the coefficient fraction, rounding toward minus infinity
  assign acc_sh = acc >>> COEF_FRAC;

  // Passthrough value in state format
  assign pass_v = $signed({{(AW-XQ_W){1'b0}}, sample, {FRAC_BITS{1'b0}}});

  // Select and saturate to the state range
  always_comb begin
    sel = use_plant ? acc_sh : pass_v;
    if (sel > ST_MAX) begin
      y = ST_MAX[STATE_WIDTH-1:0];
    end else if (sel < ST_MIN) begin
      y = ST_MIN[STATE_WIDTH-1:0];
    end else begin
      y = sel[STATE_WIDTH-1:0];
    end
  end

  // Advance the history on every transaction that leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      hist_one_r    <= '0;
      hist_two_r    <= '0;
    end else if (step) begin
      last_sample_r <= sample;
      hist_one_r    <= y;
      hist_two_r    <= hist_one_r;
    end
  end

endmodule

// ===== src/second_order_plant_model.sv =====
// Second-order plant model: one 8-bit output transaction for each input
// transaction, one transaction per clock cycle sustained while out_ready is
// high. Each input is held in the input register, its result in the result
// register; the whole recurrence, three Q2.14 products into the saturated
// state, is combinational between them, so the previous output feeds back
// with no extra register. plant_mode is written through cfg_wr_en/cfg_wr_data
// only while idle; the user must ensure this, the block does not enforce it.
// Depends on sopm_pkg and sopm_recur.
module second_order_plant_model import sopm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_drive_high,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_value,
  input  logic                cfg_wr_en,
  input  logic [MODE_W-1:0]   cfg_wr_data
);

  logic [MODE_W-1:0]             plant_mode_r;
  logic                          s1_valid_r, out_valid_r;
  logic [SAMPLE_W-1:0]           s1_sample_r;
  logic                          s1_drive_r;
  logic [OUT_W-1:0]              out_value_r, out_value_nxt;
  logic                          s1_adv;
  logic signed [STATE_WIDTH-1:0] y;

  // Handshake: input register moves on when the result register is free
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Hold the plant mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plant_mode_r <= '0;
    end else if (cfg_wr_en) begin
      plant_mode_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_drive_r  <= in_drive_high;
    end
  end

  sopm_recur #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_recur (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .sample     (s1_sample_r),
    .drive_high (s1_drive_r),
    .plant_mode (plant_mode_r),
    .y          (y)
  );

  // Truncate and clamp the state to the converter range
  always_comb begin
    if (y <= 0) begin
      out_value_nxt = '0;
    end else if (y[STATE_WIDTH-1:FRAC_BITS] > (STATE_WIDTH-FRAC_BITS)'(OUT_MAX)) begin
      out_value_nxt = OUT_MAX;
    end else begin
      out_value_nxt = y[FRAC_BITS+OUT_W-1:FRAC_BITS];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r <= out_value_nxt;
    end
  end

endmodule

// ===== bench/second_order_plant_checker.sv =====
// Checker for the second-order plant model: watches the input, result and
// mode-write ports, predicts each output code and compares it in order.
// Depends on sopm_pkg.
module second_order_plant_checker import sopm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_drive_high,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [OUT_W-1:0]    out_value,
  input  logic                cfg_wr_en,
  input  logic [MODE_W-1:0]   cfg_wr_data,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Q2.14 coefficient sets, indexed by plant mode minus one
  localparam int GAIN_B  [4] = '{958, 1316, 1453, 1092};
  localparam int GAIN_A1 [4] = '{22086, 28475, 31310, 24281};
  localparam int GAIN_A2 [4] = '{6662, 13414, 16384, 8992};

  logic [MODE_W-1:0]             plant_mode_q;
  logic [SAMPLE_W-1:0]           prev_sample;
  logic signed [STATE_WIDTH-1:0] y_hist_one;
  logic signed [STATE_WIDTH-1:0] y_hist_two;
  logic [OUT_W-1:0]              expected_codes[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Clip a wide value to the signed state range
  function automatic logic signed [STATE_WIDTH-1:0] clip_to_state(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[STATE_WIDTH-1:0];
    if (v < lo) return lo[STATE_WIDTH-1:0];
    return v[STATE_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin : track
    int                            k;
    longint                        acc;
    longint                        whole;
    logic signed [STATE_WIDTH-1:0] y;
    logic [OUT_W-1:0]              code;
    logic [OUT_W-1:0]              want;
    if (!rst_n) begin
      plant_mode_q = '0;
      prev_sample  = '0;
      y_hist_one   = '0;
      y_hist_two   = '0;
      expected_codes.delete();
    end else begin
      // Advance the plant on each accepted input transaction
      if (in_valid && in_ready) begin
        if (in_drive_high && plant_mode_q >= MODE_PLANT_FIRST &&
            plant_mode_q <= MODE_PLANT_LAST) begin
          k   = int'(plant_mode_q) - 1;
          acc = longint'(GAIN_B[k]) * (longint'(prev_sample) <<< FRAC_BITS)
              + longint'(GAIN_A1[k]) * longint'(y_hist_one)
              - longint'(GAIN_A2[k]) * longint'(y_hist_two);
          y   = clip_to_state(acc >>> COEF_FRAC);
        end else begin
          y = clip_to_state(longint'(in_sample) <<< FRAC_BITS);
        end
        y_hist_two  = y_hist_one;
        y_hist_one  = y;
        prev_sample = in_sample;
        // Truncate toward zero, then clamp to the converter range
        if (y <= 0) begin
          code = '0;
        end else begin
          whole = longint'(y) >>> FRAC_BITS;
          code  = (whole > longint'(OUT_MAX)) ? OUT_MAX : whole[OUT_W-1:0];
        end
        expected_codes.push_back(code);
      end

      // Compare each result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t ns: out_value %0d arrived with nothing expected", $time, out_value);
          mismatches++;
        end else begin
          want = expected_codes.pop_front();
          if (out_value !== want) begin
            $display("%0t ns: out_value expected %0d, got %0d", $time, want, out_value);
            mismatches++;
          end
        end
      end

      // Mode writes land only while idle
      if (cfg_wr_en) plant_mode_q = cfg_wr_data;
    end
    pending = expected_codes.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the second-order plant model bench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict.
// Depends on sopm_pkg, second_order_plant_model and second_order_plant_checker.
module testbench;
  import sopm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS   = 560;
  localparam int CALM_ITEMS    = 60;
  localparam int LONG_HOLD     = 40;
  localparam int HOLD_AT_ITEM  = 200;
  localparam int WATCHDOG_IDLE = 2000;
  localparam int DRAIN_CYCLES  = 8;

  // Mode codes used by name in the directed part
  localparam logic [MODE_W-1:0] MODE_PASS_LOW       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLANT_UNDAMPED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PASS_HIGH      = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                in_drive_high = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_W-1:0]    out_value;
  logic                cfg_wr_en = 1'b0;
  logic [MODE_W-1:0]   cfg_wr_data = '0;

  int mismatches;
  int pending;
  int sent_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit sender_gappy = 1'b1;

  second_order_plant_model DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_drive_high (in_drive_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  second_order_plant_checker plant_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_drive_high (in_drive_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one sample transaction and hold it until accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic d);
    if (!calm && sender_gappy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_drive_high <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (sent_count == HOLD_AT_ITEM) hold_req = 1'b1;
    if (sent_count >= TOTAL_ITEMS - CALM_ITEMS) calm = 1'b1;
  endtask

  // Drain the block, then write the plant mode
  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: random ready bursts, one long hold, always ready when calm
  initial begin
    @(posedge rst_n);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
          end
          1: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(30, 80)) @(posedge clk);
          end
          default: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_IDLE) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    int                  phase;
    int                  phase_len;
    int                  half_period;
    int                  style;
    int                  remaining;
    logic [MODE_W-1:0]   m;
    logic                drv;
    logic [SAMPLE_W-1:0] lvl_hi;
    logic [SAMPLE_W-1:0] lvl_lo;
    logic [SAMPLE_W-1:0] s;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Passthrough with either drive level, extremes and alternating bits
    write_mode(MODE_PASS_LOW);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    send_sample(8'd170, 1'b0);
    send_sample(8'd85, 1'b1);
    // Full-scale step through the first plant
    write_mode(MODE_PLANT_FIRST);
    repeat (6) send_sample(8'd255, 1'b1);
    // Undamped plant kicked from full scale: drives the output into the high clamp
    write_mode(MODE_PLANT_UNDAMPED);
    send_sample(8'd255, 1'b0);
    repeat (8) send_sample(8'd0, 1'b1);
    // Top unused mode ignores the drive bit
    write_mode(MODE_PASS_HIGH);
    send_sample(8'd200, 1'b1);
    send_sample(8'd15, 1'b0);

    // Random phases: square-wave drive with random content per mode
    phase = 0;
    while (sent_count < TOTAL_ITEMS) begin
      if (phase < 8) m = phase[MODE_W-1:0];
      else if ($urandom_range(0, 3) == 0) m = MODE_W'($urandom_range(0, 7));
      else m = MODE_W'($urandom_range(1, 4));
      write_mode(m);
      sender_gappy = ($urandom_range(0, 2) != 0);
      phase_len    = $urandom_range(20, 60);
      remaining    = TOTAL_ITEMS - sent_count;
      if (phase_len > remaining) phase_len = remaining;
      half_period  = $urandom_range(1, 16);
      style        = $urandom_range(0, 2);
      lvl_hi       = SAMPLE_W'($urandom);
      lvl_lo       = SAMPLE_W'($urandom);
      drv          = 1'($urandom_range(0, 1));
      for (int i = 0; i < phase_len; i++) begin
        if (i % half_period == 0) drv = ~drv;
        case (style)
          0:       s = SAMPLE_W'($urandom);
          1:       s = drv ? lvl_hi : lvl_lo;
          default: s = drv ? 8'd255 : 8'd0;
        endcase
        // Occasional glitch on the drive bit
        send_sample(s, ($urandom_range(0, 15) == 0) ? ~drv : drv);
      end
      phase++;
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline to settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
